// File: design/assert_macros.svh
// Assertion macros shared by the reorder tracker modules.
// Holds clocked property wrappers only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/rfgrt_pkg.sv
// Package for the RTP frame-group reorder tracker.
// Holds status codes, FSM states and the controller/datapath command types.
`default_nettype none
package rfgrt_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int TS_W  = 32;
    localparam int SEQ_W = 16;
    localparam int CNT_W = 5;
    localparam int ST_W  = 3;

    localparam logic [ST_W-1:0] ST_STORED   = 3'd0;
    localparam logic [ST_W-1:0] ST_STALE    = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
    localparam logic [ST_W-1:0] ST_COMPLETE = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SEARCH,
        S_INSERT,
        S_CHECK,
        S_OUTPUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic classify;
        logic search;
        logic insert;
        logic check;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic stale;
    } stat_t;

    // Serial order: a newer than b
    function automatic logic seq_newer(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage
`default_nettype wire

// File: design/rfgrt_datapath.sv
// Datapath of the reorder tracker: sorted list, frame state and result register.
// Depends on rfgrt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rfgrt_datapath
    import rfgrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    input  wire logic [TS_W-1:0]  timestamp,
    input  wire logic [SEQ_W-1:0] seq_number,
    input  wire logic             marker,
    input  wire logic             frame_start,
    output logic [ST_W-1:0]       status,
    output logic                  flushed_incomplete,
    output logic [SEQ_W-1:0]      flushed_first_seq,
    output logic [CNT_W-1:0]      flushed_count,
    output logic [SEQ_W-1:0]      group_first_seq,
    output logic [CNT_W-1:0]      group_count,
    output logic                  request_update
);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int NW = $clog2(LIST_DEPTH + 1);

    // List storage, one register per entry, shifted in place
    logic [SEQ_W-1:0] seq_reg [LIST_DEPTH];
    logic             mk_reg  [LIST_DEPTH];
    logic             fs_reg  [LIST_DEPTH];

    logic [NW-1:0]    count_reg;
    logic [TS_W-1:0]  cur_ts_reg;
    logic [SEQ_W-1:0] exp_reg;
    logic             started_reg;

    // Captured request
    logic [TS_W-1:0]  in_ts_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic             in_mk_reg;
    logic             in_fs_reg;

    // Working results
    logic             stale_reg, dup_reg, ins_reg, chk_reg;
    logic [NW-1:0]    pos_reg;
    logic [ST_W-1:0]  st_reg;
    logic             fl_reg;
    logic [SEQ_W-1:0] fl_first_reg;
    logic [NW-1:0]    fl_cnt_reg;

    // Output register
    logic [ST_W-1:0]  o_st_reg;
    logic             o_fl_reg;
    logic [SEQ_W-1:0] o_fl_first_reg;
    logic [CNT_W-1:0] o_fl_cnt_reg;
    logic [SEQ_W-1:0] o_g_first_reg;
    logic [CNT_W-1:0] o_g_cnt_reg;

    // Classification of the captured request
    logic [TS_W-1:0] eff_ts;
    logic [TS_W-1:0] ts_diff;
    assign eff_ts  = started_reg ? cur_ts_reg : in_ts_reg;
    assign ts_diff = in_ts_reg - eff_ts;

    // Search: match and ordering per entry, position = number of entries older
    logic [LIST_DEPTH-1:0] hit_vec, before_vec;
    logic [NW-1:0]         pos_c;
    logic                  dup_c;
    always_comb
    begin
        pos_c = '0;
        dup_c = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            hit_vec[i]    = (NW'(i) < count_reg) && (seq_reg[i] == in_seq_reg);
            before_vec[i] = (NW'(i) < count_reg) && seq_newer(in_seq_reg, seq_reg[i]);
        end
        // insertion point: past the last entry that the new seq is newer than
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (before_vec[i])
                pos_c = NW'(i + 1);
        end
        // backward scan stops at the insertion point, so only later matches count
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (hit_vec[i] && (NW'(i) >= pos_c))
                dup_c = 1'b1;
        end
    end

    // Completeness of the list
    logic [IW-1:0]  last_idx;
    logic           contig;
    logic           complete_c;
    assign last_idx = IW'(count_reg - NW'(1));
    always_comb
    begin
        contig = 1'b1;
        for (int i = 1; i < LIST_DEPTH; i++)
        begin
            if ((NW'(i) < count_reg) && (seq_reg[i] != seq_reg[0] + SEQ_W'(i)))
                contig = 1'b0;
        end
        complete_c = (count_reg != '0) && contig && mk_reg[last_idx]
                     && ((seq_reg[0] == exp_reg) || fs_reg[0]);
    end

    assign stat.stale = stale_reg;

    // Control state of the list and frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cur_ts_reg  <= '0;
            exp_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cmd.classify)
            begin
                started_reg <= 1'b1;
                if (ts_diff[TS_W-1])
                begin
                    if (!seq_newer(exp_reg, in_seq_reg))
                        exp_reg <= in_seq_reg + SEQ_W'(1);
                end
                else if (ts_diff != '0)
                begin
                    cur_ts_reg <= in_ts_reg;
                    if (count_reg != '0)
                    begin
                        exp_reg   <= seq_reg[last_idx] + SEQ_W'(1);
                        count_reg <= '0;
                    end
                end
                else
                    cur_ts_reg <= eff_ts;
            end
            if (cmd.insert && ins_reg)
                count_reg <= count_reg + NW'(1);
            if (cmd.check && chk_reg && complete_c)
            begin
                exp_reg   <= seq_reg[last_idx] + SEQ_W'(1);
                count_reg <= '0;
            end
        end
    end

    // Payload, working and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_ts_reg  <= timestamp;
            in_seq_reg <= seq_number;
            in_mk_reg  <= marker;
            in_fs_reg  <= frame_start;
        end
        if (cmd.classify)
        begin
            stale_reg    <= ts_diff[TS_W-1];
            chk_reg      <= ts_diff[TS_W-1];
            ins_reg      <= 1'b0;
            st_reg       <= ts_diff[TS_W-1] ? ST_STALE : ST_STORED;
            fl_reg       <= !ts_diff[TS_W-1] && (ts_diff != '0) && (count_reg != '0);
            fl_first_reg <= seq_reg[0];
            fl_cnt_reg   <= count_reg;
        end
        if (cmd.search)
        begin
            dup_reg <= dup_c;
            pos_reg <= pos_c;
            if (dup_c)
                st_reg <= ST_DUP;
            else if (count_reg >= NW'(LIST_DEPTH))
                st_reg <= ST_OVERFLOW;
            else
            begin
                ins_reg <= 1'b1;
                chk_reg <= 1'b1;
            end
        end
        if (cmd.insert && ins_reg)
        begin
            for (int k = 0; k < LIST_DEPTH; k++)
            begin
                if (NW'(k) == pos_reg)
                begin
                    seq_reg[k] <= in_seq_reg;
                    mk_reg[k]  <= in_mk_reg;
                    fs_reg[k]  <= in_fs_reg;
                end
                else if ((k > 0) && (NW'(k) > pos_reg) && (NW'(k) <= count_reg))
                begin
                    seq_reg[k] <= seq_reg[k-1];
                    mk_reg[k]  <= mk_reg[k-1];
                    fs_reg[k]  <= fs_reg[k-1];
                end
            end
        end
        if (cmd.check)
        begin
            o_st_reg       <= (chk_reg && complete_c) ? ST_COMPLETE : st_reg;
            o_g_first_reg  <= (chk_reg && complete_c) ? seq_reg[0] : '0;
            o_g_cnt_reg    <= (chk_reg && complete_c) ? CNT_W'(count_reg) : '0;
            o_fl_reg       <= fl_reg;
            o_fl_first_reg <= fl_reg ? fl_first_reg : '0;
            o_fl_cnt_reg   <= fl_reg ? CNT_W'(fl_cnt_reg) : '0;
        end
    end

    assign status             = o_st_reg;
    assign flushed_incomplete = o_fl_reg;
    assign flushed_first_seq  = o_fl_first_reg;
    assign flushed_count      = o_fl_cnt_reg;
    assign group_first_seq    = o_g_first_reg;
    assign group_count        = o_g_cnt_reg;
    assign request_update     = o_fl_reg;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= NW'(LIST_DEPTH))
    `ASSERT_NEXT(a_ins_grows, clk, rst_n, cmd.insert && ins_reg && count_reg < NW'(LIST_DEPTH),
                 count_reg == $past(count_reg) + NW'(1))
    `ASSERT_IMPL(a_no_dup_ins, clk, rst_n, cmd.insert, !(ins_reg && dup_reg))

endmodule
`default_nettype wire

// File: design/rfgrt_ctrl.sv
// Controller FSM of the reorder tracker: sequences classify, search, insert, check.
// Depends on rfgrt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rfgrt_ctrl
    import rfgrt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (stat.stale)
                    state_next = S_CHECK;
                else
                begin
                    cmd.search = 1'b1;
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // wait until the previous result has gone
                if (!ov_next)
                begin
                    cmd.check  = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

    `ASSERT_NEXT(a_check_sets_valid, clk, rst_n, cmd.check, out_valid)
    `ASSERT_IMPL(a_no_load_busy, clk, rst_n, cmd.load, state_reg == S_IDLE)

endmodule
`default_nettype wire

// File: design/rtp_frame_group_reorder_tracker_core.sv
// A request steps through classify, search, insert and check from input to result; stale packets
// skip the search and insert commands. A new request is taken only in the idle state, once the
// controller has stepped through the sorted-list update one phase at a time.
// The output register lets the next request start while a result waits.
// Reset (rst_n, asynchronous): list empty, timestamp unset, expected seq zero.
`default_nettype none
module rtp_frame_group_reorder_tracker_core
    import rfgrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [TS_W-1:0]  timestamp,
    input  wire logic [SEQ_W-1:0] seq_number,
    input  wire logic             marker,
    input  wire logic             frame_start,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [ST_W-1:0]       status,
    output logic                  flushed_incomplete,
    output logic [SEQ_W-1:0]      flushed_first_seq,
    output logic [CNT_W-1:0]      flushed_count,
    output logic [SEQ_W-1:0]      group_first_seq,
    output logic [CNT_W-1:0]      group_count,
    output logic                  request_update
);
    cmd_t  cmd;
    stat_t stat;

    rfgrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rfgrt_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .timestamp          (timestamp),
        .seq_number         (seq_number),
        .marker             (marker),
        .frame_start        (frame_start),
        .status             (status),
        .flushed_incomplete (flushed_incomplete),
        .flushed_first_seq  (flushed_first_seq),
        .flushed_count      (flushed_count),
        .group_first_seq    (group_first_seq),
        .group_count        (group_count),
        .request_update     (request_update)
    );

endmodule
`default_nettype wire
